// ===== hw/rtl/bbl_pkg.sv =====
package bbl_pkg;

	localparam int COS_STEPS = 360;
	localparam int DUTY_BITS = 16;

	localparam int MV_W     = 16;
	localparam int DUTY_W   = 16;
	localparam int PER_FRAC = 8;
	localparam int LVL_W    = MV_W + 1;
	localparam int CNT_W    = 17;
	localparam int PER_W    = CNT_W + PER_FRAC;
	localparam int PH_W     = $clog2(COS_STEPS);
	localparam int HALF     = COS_STEPS / 2;
	localparam int K_W      = $clog2(HALF + 1);
	localparam int S2_W     = DUTY_BITS + 1;
	localparam int MA_W     = 16;
	localparam int MB_W     = (S2_W > LVL_W) ? S2_W : LVL_W;
	localparam int PROD_W   = MA_W + MB_W;
	localparam int QS_W     = (PH_W > MV_W) ? PH_W : MV_W;
	localparam int REM_W    = PER_W + 1;
	localparam int NUM_W    = PER_W + PH_W;
	localparam int MAX_STEP = (MB_W > QS_W) ? MB_W : QS_W;
	localparam int STEP_W   = $clog2(MAX_STEP + 1);
	localparam int REG_W    = 3;

	localparam logic [LVL_W-1:0]  LVL_ONE  = LVL_W'(1) << MV_W;
	localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

	typedef enum logic [REG_W-1:0] {
		REG_EMPTY_MV    = 3'd0,
		REG_FULL_MV     = 3'd1,
		REG_PER_EMPTY   = 3'd2,
		REG_PER_FULL    = 3'd3,
		REG_DUTY_NORMAL = 3'd4,
		REG_DUTY_FAULT  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEVEL,
		S_LDIV,
		S_PMUL_LD,
		S_PMUL,
		S_PERIOD,
		S_COUNT,
		S_PHASE,
		S_PDIV,
		S_TABLE,
		S_DMUL,
		S_DONE
	} state_t;

	typedef longint unsigned u64_t;
	typedef logic [S2_W-1:0] s2_tab_t [0:HALF];

	// shape^2 for a phase already folded into 0..half turn
	function automatic logic [S2_W-1:0] s2_entry(input int k);
		u64_t   y;
		u64_t   y2;
		u64_t   t;
		u64_t   sq;
		u64_t   r;
		u64_t   s2v;
		longint s;
		y  = (64'd3373259426 * u64_t'(k)) / COS_STEPS;
		y2 = (y * y) >> 30;
		t  = y;
		s  = longint'(y);
		t  = ((t * y2) >> 30) / 6;
		s  = s - longint'(t);
		t  = ((t * y2) >> 30) / 20;
		s  = s + longint'(t);
		t  = ((t * y2) >> 30) / 42;
		s  = s - longint'(t);
		t  = ((t * y2) >> 30) / 72;
		s  = s + longint'(t);
		t  = ((t * y2) >> 30) / 110;
		s  = s - longint'(t);
		t  = ((t * y2) >> 30) / 156;
		s  = s + longint'(t);
		if (s < 0) begin
			s = 0;
		end
		if (s > 64'sd1073741824) begin
			s = 64'sd1073741824;
		end
		sq  = (u64_t'(s) * u64_t'(s)) >> 30;
		r   = (sq + (64'd1 << (29 - DUTY_BITS))) >> (30 - DUTY_BITS);
		s2v = (r * r + (64'd1 << (DUTY_BITS - 1))) >> DUTY_BITS;
		return s2v[S2_W-1:0];
	endfunction

	function automatic s2_tab_t build_s2_tab();
		s2_tab_t tab;
		for (int k = 0; k <= HALF; k++) begin
			tab[k] = s2_entry(k);
		end
		return tab;
	endfunction

	localparam s2_tab_t S2_TAB = build_s2_tab();

endpackage

// ===== hw/rtl/bbl_ifs.sv =====
interface bbl_upd_if import bbl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MV_W-1:0]   voltage_mv;
	logic              fault_flag;
	logic [MV_W-1:0]   step_ms;

	modport source(output valid, voltage_mv, fault_flag, step_ms, input ready);
	modport sink(input valid, voltage_mv, fault_flag, step_ms, output ready);
endinterface

interface bbl_res_if import bbl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty;
	logic              cycle_restart;

	modport source(output valid, duty, cycle_restart, input ready);
	modport sink(input valid, duty, cycle_restart, output ready);
endinterface

interface bbl_cfg_if import bbl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REG_W-1:0]  index;
	logic [MV_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/battery_breathing_led_core.sv =====
// channel | dir | beat contents
// --------+-----+---------------------------------------------
// upd     | in  | voltage_mv, fault_flag, step_ms
// res     | out | duty, cycle_restart (one beat per upd beat)
// cfg     | in  | index, data (register write, always ready)
//
// The level divide runs only when the voltage lies between the empty and full levels and is
// skipped when the voltage is clamped. The sequencer uses a bit-serial restoring divider (16 steps
// for the level, 9 for the phase) and a shift-add multiplier (17 steps each for
// period and duty). arst_n clears the sequencer, the counter and loads register
// defaults. res has an output register: a new upd beat is taken while a result waits.
module battery_breathing_led_core import bbl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bbl_cfg_if.sink    cfg,
	bbl_upd_if.sink    upd,
	bbl_res_if.source  res
);

	state_t              state_q, state_d;

	logic [MV_W-1:0]     empty_mv_q, full_mv_q, per_empty_q, per_full_q;
	logic [MV_W-1:0]     duty_normal_q, duty_fault_q;
	logic [CNT_W-1:0]    elapsed_q;

	logic [MV_W-1:0]     volt_q, step_ms_q;
	logic                fault_q;
	logic [LVL_W-1:0]    level_q;
	logic [PER_W-1:0]    period_q;
	logic                per_up_q;
	logic [CNT_W-1:0]    e_q;
	logic                restart_q;

	logic [REM_W-1:0]    rem_q;
	logic [PER_W-1:0]    dvs_q;
	logic [QS_W-1:0]     qsh_q;
	logic [MA_W-1:0]     mhi_q, mcand_q;
	logic [MB_W-1:0]     mlo_q;
	logic [STEP_W-1:0]   step_cnt_q;

	logic                out_valid_q, out_restart_q;
	logic [DUTY_W-1:0]   out_duty_q;

	logic                accept, out_load, last_step;

	// divider step
	logic [REM_W-1:0]    rem_sh, rem_nx;
	logic                div_ge;
	logic [QS_W-1:0]     qsh_nx;

	// multiplier step
	logic [MA_W:0]       mul_sum;
	logic [PROD_W-1:0]   prod;

	logic [MV_W-1:0]     lvl_num;
	logic [PER_W-1:0]    per_base, per_inc, per_dec, per_raw;
	logic [PROD_W:0]     prod_rnd;
	logic [CNT_W-1:0]    e_sum;
	logic [NUM_W-1:0]    ph_num;
	logic [PH_W-1:0]     idx, idx_c;
	logic [K_W-1:0]      k_idx;
	logic [PROD_W:0]     duty_sum, duty_sh;

	assign accept    = upd.valid && upd.ready;
	assign last_step = (step_cnt_q == STEP_W'(1));
	assign cfg.ready = 1'b1;

	assign res.valid         = out_valid_q;
	assign res.duty          = out_duty_q;
	assign res.cycle_restart = out_restart_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (upd.valid) state_d = S_LEVEL;
			end
			S_LEVEL: begin
				if (full_mv_q > empty_mv_q && volt_q > empty_mv_q && volt_q < full_mv_q)
					state_d = S_LDIV;
				else
					state_d = S_PMUL_LD;
			end
			S_LDIV: begin
				if (last_step) state_d = S_PMUL_LD;
			end
			S_PMUL_LD: state_d = S_PMUL;
			S_PMUL: begin
				if (last_step) state_d = S_PERIOD;
			end
			S_PERIOD: state_d = S_COUNT;
			S_COUNT:  state_d = S_PHASE;
			S_PHASE:  state_d = S_PDIV;
			S_PDIV: begin
				if (last_step) state_d = S_TABLE;
			end
			S_TABLE: state_d = S_DMUL;
			S_DMUL: begin
				if (last_step) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || res.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		upd.ready = (state_q == S_IDLE);
		out_load  = (state_q == S_DONE) && (!out_valid_q || res.ready);
	end

	always_comb begin
		rem_sh  = {rem_q[REM_W-2:0], qsh_q[QS_W-1]};
		div_ge  = (rem_sh >= {1'b0, dvs_q});
		rem_nx  = div_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		qsh_nx  = {qsh_q[QS_W-2:0], div_ge};

		mul_sum = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, mcand_q} : {(MA_W+1){1'b0}});
		prod    = {mhi_q, mlo_q};

		lvl_num  = volt_q - empty_mv_q;
		per_base = PER_W'({per_empty_q, {PER_FRAC{1'b0}}});
		per_inc  = PER_W'(prod >> PER_FRAC);
		prod_rnd = {1'b0, prod} + (PROD_W+1)'((1 << PER_FRAC) - 1);
		per_dec  = PER_W'(prod_rnd >> PER_FRAC);
		per_raw  = per_up_q ? (per_base + per_inc) : (per_base - per_dec);

		e_sum  = elapsed_q + CNT_W'(step_ms_q);
		ph_num = NUM_W'(COS_STEPS) * NUM_W'({e_q, {PER_FRAC{1'b0}}});

		idx   = qsh_q[PH_W-1:0];
		idx_c = (idx >= PH_W'(COS_STEPS)) ? PH_W'(COS_STEPS - 1) : idx;
		if ({idx_c, 1'b0} > (PH_W+1)'(COS_STEPS))
			k_idx = K_W'(PH_W'(COS_STEPS) - idx_c);
		else
			k_idx = K_W'(idx_c);

		duty_sum = {1'b0, prod} + ((PROD_W+1)'(1) << (DUTY_BITS - 1));
		duty_sh  = duty_sum >> DUTY_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			elapsed_q     <= '0;
			empty_mv_q    <= 16'd6400;
			full_mv_q     <= 16'd8400;
			per_empty_q   <= 16'd500;
			per_full_q    <= 16'd3000;
			duty_normal_q <= 16'd16384;
			duty_fault_q  <= 16'd65535;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			if (state_q == S_COUNT) begin
				if ({e_sum, {PER_FRAC{1'b0}}} >= period_q)
					elapsed_q <= '0;
				else
					elapsed_q <= e_sum;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_EMPTY_MV:    empty_mv_q    <= cfg.data;
					REG_FULL_MV:     full_mv_q     <= cfg.data;
					REG_PER_EMPTY:   per_empty_q   <= cfg.data;
					REG_PER_FULL:    per_full_q    <= cfg.data;
					REG_DUTY_NORMAL: duty_normal_q <= cfg.data;
					REG_DUTY_FAULT:  duty_fault_q  <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			volt_q    <= upd.voltage_mv;
			fault_q   <= upd.fault_flag;
			step_ms_q <= upd.step_ms;
		end
		unique case (state_q)
			S_LEVEL: begin
				if (full_mv_q > empty_mv_q) begin
					if (volt_q <= empty_mv_q)
						level_q <= '0;
					else
						level_q <= LVL_ONE;
				end else begin
					level_q <= (volt_q >= full_mv_q) ? LVL_ONE : '0;
				end
				rem_q      <= REM_W'(lvl_num);
				dvs_q      <= PER_W'(full_mv_q - empty_mv_q);
				qsh_q      <= '0;
				step_cnt_q <= STEP_W'(MV_W);
			end
			S_LDIV, S_PDIV: begin
				rem_q      <= rem_nx;
				qsh_q      <= qsh_nx;
				step_cnt_q <= step_cnt_q - STEP_W'(1);
				if (state_q == S_LDIV && last_step)
					level_q <= LVL_W'(qsh_nx[MV_W-1:0]);
			end
			S_PMUL_LD: begin
				per_up_q   <= (per_full_q >= per_empty_q);
				mcand_q    <= (per_full_q >= per_empty_q) ? (per_full_q - per_empty_q)
				                                          : (per_empty_q - per_full_q);
				mhi_q      <= '0;
				mlo_q      <= MB_W'(level_q);
				step_cnt_q <= STEP_W'(MB_W);
			end
			S_PMUL, S_DMUL: begin
				mhi_q      <= mul_sum[MA_W:1];
				mlo_q      <= {mul_sum[0], mlo_q[MB_W-1:1]};
				step_cnt_q <= step_cnt_q - STEP_W'(1);
			end
			S_PERIOD: begin
				period_q <= (per_raw == '0) ? PER_W'(1) : per_raw;
			end
			S_COUNT: begin
				if ({e_sum, {PER_FRAC{1'b0}}} >= period_q) begin
					e_q       <= '0;
					restart_q <= 1'b1;
				end else begin
					e_q       <= e_sum;
					restart_q <= 1'b0;
				end
			end
			S_PHASE: begin
				rem_q      <= {1'b0, ph_num[NUM_W-1:PH_W]};
				dvs_q      <= period_q;
				qsh_q      <= QS_W'(ph_num[PH_W-1:0]) << (QS_W - PH_W);
				step_cnt_q <= STEP_W'(PH_W);
			end
			S_TABLE: begin
				mcand_q    <= fault_q ? duty_fault_q : duty_normal_q;
				mhi_q      <= '0;
				mlo_q      <= MB_W'(S2_TAB[k_idx]);
				step_cnt_q <= STEP_W'(MB_W);
			end
			S_IDLE, S_DONE: ;
			default: ;
		endcase
		if (out_load) begin
			out_duty_q    <= (duty_sh > (PROD_W+1)'(DUTY_MAX)) ? DUTY_MAX
			                                                 : DUTY_W'(duty_sh);
			out_restart_q <= restart_q;
		end
	end

	a_elapsed_range: assert property (@(posedge clk) disable iff (!arst_n)
		!elapsed_q[CNT_W-1])
		else $error("elapsed counter reached 2^16");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PMUL_LD) |-> (level_q <= LVL_ONE))
		else $error("level above one");

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COUNT) |-> (period_q != '0))
		else $error("zero period reached counter update");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TABLE) |-> (qsh_q[PH_W-1:0] < PH_W'(COS_STEPS)))
		else $error("phase index out of range");

endmodule
